@@ hw/rtl/gob_pkg.sv @@
// shared types, constants and cordic angle table for gradient orientation binning
`timescale 1ns / 1ps

package gob_pkg;

  // pixel and bin configuration
  localparam int GOB_PIX_W  = 8;
  localparam int GOB_BINS   = 8;
  localparam int GOB_BIN_W  = $clog2(GOB_BINS);
  localparam int GOB_A_W    = GOB_BIN_W + 8;

  // derivative in half units, magnitude of a derivative, sum of squares
  localparam int GOB_DER_W  = GOB_PIX_W + 3;
  localparam int GOB_ABS_W  = GOB_PIX_W + 2;
  localparam int GOB_SQ_W   = 2 * GOB_ABS_W;

  // cordic datapath widths: inputs scaled by 2^12 plus growth and sign
  localparam int GOB_CW     = GOB_ABS_W + 15;
  localparam int GOB_ZW     = 21;
  localparam int GOB_SW     = GOB_SQ_W + 6;
  localparam int GOB_MAG_W  = 13;
  localparam int GOB_W_W    = 13;

  // pipeline shape
  localparam int GOB_CSTG   = 8;
  localparam int GOB_STAGES = GOB_CSTG + 4;

  // bit-by-bit square root: 13 result bits, top trial bit 2^24
  localparam int GOB_SQRT_STEPS = 13;
  localparam int GOB_SQRT_TOP   = 24;

  // angles in 2^-20 turns
  localparam int GOB_OCT_MAX = 131072;
  localparam int GOB_QUARTER = 262144;
  localparam int GOB_HALF    = 524288;
  localparam int GOB_TURN_W  = 20;

  // one cordic step plus one square root step state
  typedef struct packed {
    logic signed [GOB_CW-1:0] x;
    logic signed [GOB_CW-1:0] y;
    logic signed [GOB_ZW-1:0] z;
    logic [GOB_SW-1:0]        v;
    logic [GOB_SW-1:0]        r;
  } gob_iter_t;

  // octant folding flags that ride along the cordic stages
  typedef struct packed {
    logic swp;
    logic sx;
    logic sy;
  } gob_side_t;

  // round(atan(2^-i) * 2^20 / (2*pi))
  function automatic logic signed [GOB_ZW-1:0] rot_angle(input logic [3:0] i);
    logic signed [GOB_ZW-1:0] a;
    case (i)
      4'd0:    a = 21'sd131072;
      4'd1:    a = 21'sd77376;
      4'd2:    a = 21'sd40884;
      4'd3:    a = 21'sd20753;
      4'd4:    a = 21'sd10417;
      4'd5:    a = 21'sd5213;
      4'd6:    a = 21'sd2607;
      4'd7:    a = 21'sd1304;
      4'd8:    a = 21'sd652;
      4'd9:    a = 21'sd326;
      4'd10:   a = 21'sd163;
      4'd11:   a = 21'sd81;
      4'd12:   a = 21'sd41;
      4'd13:   a = 21'sd20;
      4'd14:   a = 21'sd10;
      4'd15:   a = 21'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/gob_step.sv @@
// two cordic vectoring iterations and up to two square root iterations for one pipeline stage
`timescale 1ns / 1ps

module gob_step (
  input  logic [2:0]         stage_idx,
  input  gob_pkg::gob_iter_t iter_i,
  output gob_pkg::gob_iter_t iter_o
);

  gob_pkg::gob_iter_t                st;
  logic [3:0]                        it;
  logic signed [gob_pkg::GOB_CW-1:0] dx;
  logic signed [gob_pkg::GOB_CW-1:0] dy;
  logic signed [gob_pkg::GOB_ZW-1:0] rot;
  logic [4:0]                        sh;
  logic [gob_pkg::GOB_SW-1:0]        sbit;
  logic [gob_pkg::GOB_SW-1:0]        trial;

  // iterations 2*stage_idx and 2*stage_idx+1
  always_comb begin
    st    = iter_i;
    it    = '0;
    dx    = '0;
    dy    = '0;
    rot   = '0;
    sh    = '0;
    sbit  = '0;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      it  = {stage_idx, 1'(k)};
      // cordic: rotate toward the x axis, floor shifts
      dx  = st.y >>> it;
      dy  = st.x >>> it;
      rot = gob_pkg::rot_angle(it);
      if (!st.y[gob_pkg::GOB_CW-1] && (st.y != '0)) begin
        st.x = st.x + dx;
        st.y = st.y - dy;
        st.z = st.z + rot;
      end else if (st.y[gob_pkg::GOB_CW-1]) begin
        st.x = st.x - dx;
        st.y = st.y + dy;
        st.z = st.z - rot;
      end
      // square root: one result bit per iteration
      if (it < 4'(gob_pkg::GOB_SQRT_STEPS)) begin
        sh    = 5'(gob_pkg::GOB_SQRT_TOP) - {it, 1'b0};
        sbit  = gob_pkg::GOB_SW'(1) << sh;
        trial = st.r + sbit;
        if (st.v >= trial) begin
          st.v = st.v - trial;
          st.r = (st.r >> 1) + sbit;
        end else begin
          st.r = st.r >> 1;
        end
      end
    end
    iter_o = st;
  end

endmodule

@@ hw/rtl/gradient_orientation_binning.sv @@
// top level: streaming gradient orientation binning pipeline
`timescale 1ns / 1ps

// Takes one pixel with its four neighbors and border flags per transfer and returns the
// two adjacent orientation bins with linearly interpolated magnitude weights. The block
// sustains one item per clock while out_tready is high, in a 12-stage pipeline (derivatives,
// folding and squares, eight stages of two cordic and up to two square root iterations each,
// angle scaling, weight multiply into the output register). Each stage holds its item
// while the stage after it is occupied and blocked, so a stall on the output side fills
// bubbles first and loses nothing. A zero gradient gives bin 0, upper bin 1 and zero weights.
module gradient_orientation_binning (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // center_pixel, up_pixel, down_pixel, left_pixel, right_pixel
  input  logic [39:0] in_tdata,
  // at_top, at_bottom, at_left, at_right
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lower_bin, upper_bin, lower_weight, upper_weight
  output logic [31:0] out_tdata
);

  localparam int NS = gob_pkg::GOB_STAGES;
  localparam int NC = gob_pkg::GOB_CSTG;
  localparam int DW = gob_pkg::GOB_DER_W;
  localparam int AW = gob_pkg::GOB_ABS_W;

  // per-stage valid bits and advance chain
  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // stage 0: derivatives in half units
  logic signed [DW-1:0] c_s, up_s, dn_s, lf_s, rt_s;
  logic signed [DW-1:0] hx_nxt, hy_nxt;
  logic signed [DW-1:0] hx_r, hy_r;

  assign c_s  = signed'({3'b000, in_tdata[7:0]});
  assign up_s = signed'({3'b000, in_tdata[15:8]});
  assign dn_s = signed'({3'b000, in_tdata[23:16]});
  assign lf_s = signed'({3'b000, in_tdata[31:24]});
  assign rt_s = signed'({3'b000, in_tdata[39:32]});

  always_comb begin
    if (in_tuser[0]) begin
      hy_nxt = (dn_s - c_s) <<< 1;
    end else if (in_tuser[1]) begin
      hy_nxt = (c_s - up_s) <<< 1;
    end else begin
      hy_nxt = dn_s - up_s;
    end
    if (in_tuser[2]) begin
      hx_nxt = (rt_s - c_s) <<< 1;
    end else if (in_tuser[3]) begin
      hx_nxt = (c_s - lf_s) <<< 1;
    end else begin
      hx_nxt = rt_s - lf_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      hx_r <= hx_nxt;
      hy_r <= hy_nxt;
    end
  end

  // stage 1: octant folding and sum of squares
  logic [DW-1:0]                   hx_abs, hy_abs;
  logic [AW-1:0]                   ax, ay;
  logic [AW-1:0]                   mx_r, mn_r;
  logic [gob_pkg::GOB_SQ_W-1:0]    sq_nxt, sq_r;
  gob_pkg::gob_side_t              sd1_r;

  assign hx_abs = hx_r[DW-1] ? DW'(-hx_r) : DW'(hx_r);
  assign hy_abs = hy_r[DW-1] ? DW'(-hy_r) : DW'(hy_r);
  assign ax     = hx_abs[AW-1:0];
  assign ay     = hy_abs[AW-1:0];
  assign sq_nxt = gob_pkg::GOB_SQ_W'(ax) * gob_pkg::GOB_SQ_W'(ax)
                + gob_pkg::GOB_SQ_W'(ay) * gob_pkg::GOB_SQ_W'(ay);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      mx_r      <= (ay > ax) ? ay : ax;
      mn_r      <= (ay > ax) ? ax : ay;
      sd1_r.swp <= (ay > ax);
      sd1_r.sx  <= hx_r[DW-1];
      sd1_r.sy  <= hy_r[DW-1];
      sq_r      <= sq_nxt;
    end
  end

  // stages 2 to 9: cordic vectoring and square root
  gob_pkg::gob_iter_t it0;
  gob_pkg::gob_iter_t step_in  [NC];
  gob_pkg::gob_iter_t step_out [NC];
  gob_pkg::gob_iter_t it_r     [NC];
  gob_pkg::gob_side_t sd_in    [NC];
  gob_pkg::gob_side_t sd_r     [NC];

  always_comb begin
    it0.x = signed'({3'b000, mx_r, 12'h000});
    it0.y = signed'({3'b000, mn_r, 12'h000});
    it0.z = '0;
    it0.v = {sq_r, 6'b000000};
    it0.r = '0;
  end

  assign step_in[0] = it0;
  assign sd_in[0]   = sd1_r;

  for (genvar j = 0; j < NC; j++) begin : g_cordic
    if (j > 0) begin : g_link
      assign step_in[j] = it_r[j-1];
      assign sd_in[j]   = sd_r[j-1];
    end

    gob_step u_step (
      .stage_idx (3'(j)),
      .iter_i    (step_in[j]),
      .iter_o    (step_out[j])
    );

    always_ff @(posedge clk) begin
      if (adv[j+2]) begin
        it_r[j] <= step_out[j];
        sd_r[j] <= sd_in[j];
      end
    end
  end

  // stage 10: clamp, mirror into a full turn, scale to bins
  logic [17:0]                     oct;
  logic [18:0]                     phi;
  logic [gob_pkg::GOB_TURN_W-1:0]  turn;
  logic [39:0]                     prod;
  logic [gob_pkg::GOB_A_W-1:0]     scl;
  logic [gob_pkg::GOB_BIN_W-1:0]   lo_nxt, hi_nxt;
  logic [gob_pkg::GOB_BIN_W-1:0]   lo_r, hi_r;
  logic [7:0]                      frac_r;
  logic [gob_pkg::GOB_MAG_W-1:0]   mag_r;
  gob_pkg::gob_side_t              sdl;

  assign sdl = sd_r[NC-1];

  always_comb begin
    if (it_r[NC-1].z[gob_pkg::GOB_ZW-1]) begin
      oct = '0;
    end else if (it_r[NC-1].z > gob_pkg::GOB_ZW'(gob_pkg::GOB_OCT_MAX)) begin
      oct = 18'(gob_pkg::GOB_OCT_MAX);
    end else begin
      oct = it_r[NC-1].z[17:0];
    end
    phi = sdl.swp ? 19'(gob_pkg::GOB_QUARTER) - {1'b0, oct} : {1'b0, oct};
    if (!sdl.sx && !sdl.sy) begin
      turn = {1'b0, phi};
    end else if (sdl.sx && !sdl.sy) begin
      turn = 20'(gob_pkg::GOB_HALF) - {1'b0, phi};
    end else if (sdl.sx) begin
      turn = 20'(gob_pkg::GOB_HALF) + {1'b0, phi};
    end else begin
      turn = 20'd0 - {1'b0, phi};
    end
    prod   = 40'(turn) * 40'(gob_pkg::GOB_BINS * 256);
    scl    = prod[gob_pkg::GOB_TURN_W +: gob_pkg::GOB_A_W];
    lo_nxt = scl[gob_pkg::GOB_A_W-1:8];
    hi_nxt = (lo_nxt == gob_pkg::GOB_BIN_W'(gob_pkg::GOB_BINS - 1)) ? '0 : lo_nxt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (adv[NS-2]) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      frac_r <= scl[7:0];
      mag_r  <= it_r[NC-1].r[gob_pkg::GOB_MAG_W-1:0];
    end
  end

  // stage 11: interpolated weights into the output register
  logic [21:0]                  lw_prod, uw_prod;
  logic [gob_pkg::GOB_W_W-1:0]  lw_r, uw_r;
  logic [2:0]                   lb_r, ub_r;

  assign lw_prod = 22'(mag_r) * 22'(9'd256 - {1'b0, frac_r});
  assign uw_prod = 22'(mag_r) * 22'(frac_r);

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      lb_r <= 3'(lo_r);
      ub_r <= 3'(hi_r);
      lw_r <= lw_prod[8 +: gob_pkg::GOB_W_W];
      uw_r <= uw_prod[8 +: gob_pkg::GOB_W_W];
    end
  end

  assign out_tdata = {uw_r, lw_r, ub_r, lb_r};

  // an empty output register lets the whole chain move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with output register empty");

  // a blocked cordic stage keeps its item and its data
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[7] && !adv[8]) |=> (vld_r[7] && $stable(it_r[5]) && $stable(sd_r[5])))
    else $error("blocked pipeline stage lost or changed its item");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_tvalid && (vld_r == '0)))
    else $error("pipeline not empty after reset");

endmodule
